FILE: rtl/sde_pkg.sv
// ----------------------------------------------------------------------------
// Sample delta escape encoder package
// Shared widths, constants and the coded sample type that passes from the
// front end through the queue to the byte serialiser.
// ----------------------------------------------------------------------------
package sde_pkg;

  // Temperature, humidity and pressure, handled in that order.
  localparam int NumFields = 3;
  localparam int FieldIdxWidth = $clog2(NumFields);
  localparam logic [FieldIdxWidth-1:0] FieldFirst = FieldIdxWidth'(0);
  localparam logic [FieldIdxWidth-1:0] FieldLast = FieldIdxWidth'(NumFields - 1);

  // Field indexes.
  localparam int FieldTemp = 0;
  localparam int FieldHumid = 1;
  localparam int FieldPress = 2;

  // Clamped values and references are 17-bit signed, deltas 18-bit signed.
  localparam int RefWidth = 17;
  localparam int DeltaWidth = 18;
  localparam int WordWidth = 16;

  // Clamping limits.
  localparam logic signed [31:0] TempMin = -32'sd32767;
  localparam logic signed [31:0] TempMax = 32'sd32767;
  localparam logic signed [31:0] ScaleMin = 32'sd0;
  localparam logic signed [31:0] ScaleMax = 32'sd65534;

  // Words sent for an absent field.
  localparam logic [WordWidth-1:0] TempSentinel = 16'h8000;
  localparam logic [WordWidth-1:0] ScaleSentinel = 16'hFFFF;

  // Short-form delta range; minus one is reserved and goes through the escape.
  localparam logic signed [DeltaWidth-1:0] DeltaLo = -18'sd127;
  localparam logic signed [DeltaWidth-1:0] DeltaHi = 18'sd127;
  localparam logic signed [DeltaWidth-1:0] DeltaReserved = -18'sd1;

  localparam logic [7:0] EscapeByte = 8'h80;

  // One field after classification: either a single delta byte in the low
  // half of word, or an escape followed by the whole word.
  typedef struct packed {
    logic                 esc;
    logic [WordWidth-1:0] word;
  } field_code_t;

  typedef field_code_t [NumFields-1:0] sample_code_t;

  // Byte position within one field, one-hot.
  typedef enum logic [2:0] {
    BYTE_FIRST = 3'b001,
    BYTE_LOW   = 3'b010,
    BYTE_HIGH  = 3'b100
  } byte_pos_t;

  // Clamp a raw 32-bit reading into its field's range.
  function automatic logic signed [RefWidth-1:0] clamp_field(
    input logic signed [31:0] value,
    input logic signed [31:0] lo,
    input logic signed [31:0] hi
  );
    logic signed [31:0] result;
    priority if (value < lo) begin
      result = lo;
    end else if (value > hi) begin
      result = hi;
    end else begin
      result = value;
    end
    return result[RefWidth-1:0];
  endfunction

endpackage

FILE: rtl/sde_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one environmental sample per beat.
// ----------------------------------------------------------------------------
interface sde_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temp_value;
  logic               temp_present;
  logic signed [31:0] humid_value;
  logic               humid_present;
  logic signed [31:0] press_value;
  logic               press_present;

  modport source (
    output valid, temp_value, temp_present, humid_value, humid_present,
           press_value, press_present,
    input  ready
  );

  modport sink (
    input  valid, temp_value, temp_present, humid_value, humid_present,
           press_value, press_present,
    output ready
  );
endinterface

FILE: rtl/sde_byte_if.sv
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel that carries one encoded byte per beat.
// ----------------------------------------------------------------------------
interface sde_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (
    output valid, out_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last_byte,
    output ready
  );
endinterface

FILE: rtl/sde_front.sv
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts samples, clamps each field, takes its delta against the stored
// reference and classifies it as short or escaped. Updates the references.
// ----------------------------------------------------------------------------
module sde_front (
  input  logic                  clk,
  input  logic                  rst,
  sde_sample_if.sink            sample_in,
  input  logic                  full,
  output logic                  push,
  output sde_pkg::sample_code_t code
);

  logic signed [31:0]                  raw     [sde_pkg::NumFields];
  logic                                present [sde_pkg::NumFields];
  logic signed [sde_pkg::RefWidth-1:0] field_ref [sde_pkg::NumFields];

  // Gather the fields into arrays so that each lane below is identical.
  always_comb begin
    raw[sde_pkg::FieldTemp]      = sample_in.temp_value;
    raw[sde_pkg::FieldHumid]     = sample_in.humid_value;
    raw[sde_pkg::FieldPress]     = sample_in.press_value;
    present[sde_pkg::FieldTemp]  = sample_in.temp_present;
    present[sde_pkg::FieldHumid] = sample_in.humid_present;
    present[sde_pkg::FieldPress] = sample_in.press_present;
  end

  // A sample is taken whenever the queue has room for it.
  assign sample_in.ready = !full;
  assign push            = sample_in.valid && !full;

  for (genvar f = 0; f < sde_pkg::NumFields; f++) begin : g_field
    localparam logic signed [31:0] Lo =
      (f == sde_pkg::FieldTemp) ? sde_pkg::TempMin : sde_pkg::ScaleMin;
    localparam logic signed [31:0] Hi =
      (f == sde_pkg::FieldTemp) ? sde_pkg::TempMax : sde_pkg::ScaleMax;
    localparam logic [sde_pkg::WordWidth-1:0] Sentinel =
      (f == sde_pkg::FieldTemp) ? sde_pkg::TempSentinel : sde_pkg::ScaleSentinel;

    logic signed [sde_pkg::RefWidth-1:0]   clamped;
    logic signed [sde_pkg::DeltaWidth-1:0] delta;
    logic                                  is_short;

    // Clamp, then difference against the reference.
    assign clamped  = sde_pkg::clamp_field(raw[f], Lo, Hi);
    assign delta    = {clamped[sde_pkg::RefWidth-1], clamped}
                    - {field_ref[f][sde_pkg::RefWidth-1], field_ref[f]};
    assign is_short = (delta >= sde_pkg::DeltaLo) && (delta <= sde_pkg::DeltaHi)
                   && (delta != sde_pkg::DeltaReserved);

    // Classification for the serialiser.
    always_comb begin
      code[f].esc = !present[f] || !is_short;
      priority if (!present[f]) begin
        code[f].word = Sentinel;
      end else if (is_short) begin
        code[f].word = {8'h00, delta[7:0]};
      end else begin
        code[f].word = clamped[sde_pkg::WordWidth-1:0];
      end
    end

    // The reference follows every present value; absent fields leave it.
    always_ff @(posedge clk) begin
      if (rst) begin
        field_ref[f] <= '0;
      end else if (push && present[f]) begin
        field_ref[f] <= clamped;
      end
    end
  end

endmodule

FILE: rtl/sde_queue.sv
// ----------------------------------------------------------------------------
// Coded sample queue
// Short first-in first-out queue between the front end and the serialiser.
// The head entry is visible without a pop; depth must be at least two.
// ----------------------------------------------------------------------------
module sde_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sde_pkg::sample_code_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output sde_pkg::sample_code_t head
);

  localparam int PtrWidth   = $clog2(DEPTH);
  localparam int CountWidth = $clog2(DEPTH + 1);

  sde_pkg::sample_code_t entry [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CountWidth-1:0] count;

  assign full       = (count == CountWidth'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entry[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/sde_back.sv
// ----------------------------------------------------------------------------
// Encoder byte serialiser
// Walks the head entry of the queue field by field and byte by byte, one
// byte per cycle while the output register is empty or being taken, into
// that register, and pops the entry after its last byte.
// ----------------------------------------------------------------------------
module sde_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  sde_pkg::sample_code_t head,
  output logic                  pop,
  sde_byte_if.source            byte_out
);

  logic [sde_pkg::FieldIdxWidth-1:0] fld;
  sde_pkg::byte_pos_t                pos;
  sde_pkg::field_code_t              cur;
  logic [7:0]                        next_byte;
  logic                              field_done;
  logic                              sample_done;
  logic                              load;

  assign cur = head[fld];

  // Select the byte for the current position.
  always_comb begin
    unique case (pos)
      sde_pkg::BYTE_FIRST: next_byte = cur.esc ? sde_pkg::EscapeByte : cur.word[7:0];
      sde_pkg::BYTE_LOW:   next_byte = cur.word[7:0];
      sde_pkg::BYTE_HIGH:  next_byte = cur.word[15:8];
      default:             next_byte = cur.word[7:0];
    endcase
  end

  assign field_done  = !cur.esc || (pos == sde_pkg::BYTE_HIGH);
  assign sample_done = field_done && (fld == sde_pkg::FieldLast);

  // A byte moves into the output register when it is empty or being taken.
  assign load = head_valid && (!byte_out.valid || byte_out.ready);
  assign pop  = load && sample_done;

  // Position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      fld <= sde_pkg::FieldFirst;
      pos <= sde_pkg::BYTE_FIRST;
    end else if (load) begin
      if (field_done) begin
        pos <= sde_pkg::BYTE_FIRST;
        fld <= sample_done ? sde_pkg::FieldFirst : fld + 1'b1;
      end else begin
        pos <= (pos == sde_pkg::BYTE_FIRST) ? sde_pkg::BYTE_LOW : sde_pkg::BYTE_HIGH;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_out.valid <= 1'b0;
    end else if (load) begin
      byte_out.valid <= 1'b1;
    end else if (byte_out.ready) begin
      byte_out.valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_out.out_byte  <= next_byte;
      byte_out.last_byte <= sample_done;
    end
  end

endmodule

FILE: rtl/sample_delta_escape_encoder_unit.sv
// ----------------------------------------------------------------------------
// Sample delta escape encoder
// Encodes environmental samples as delta bytes with an escape form.
//
//   Port       Role    Beat carries
//   sample_in  sink    temp/humid/press value and present flag
//   byte_out   source  out_byte, last_byte (set on the final byte of a sample)
//
// Each sample produces 3 to 9 bytes, one byte per cycle while byte_out takes
// them; the serialiser's byte walk sets the rate. With the queue empty, the
// first byte of a sample passes through the queue entry and then the output
// register before it is offered.
// The front end takes a new sample whenever the queue has room, also while
// bytes of earlier samples are still waiting at the output.
// Reset clears the field references to zero and empties the queue.
// ----------------------------------------------------------------------------
module sample_delta_escape_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  sde_sample_if.sink   sample_in,
  sde_byte_if.source   byte_out
);

  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  head_valid;
  sde_pkg::sample_code_t push_data;
  sde_pkg::sample_code_t head;

  // Clamp, delta and classification.
  sde_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_in),
    .full      (full),
    .push      (push),
    .code      (push_data)
  );

  // Decoupling queue.
  sde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Byte serialiser.
  sde_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .byte_out   (byte_out)
  );

endmodule
